@@ sv/cpu_execute_unit_8bit_macros.svh @@
// assertion macros for the checker file
`ifndef CPU_EXECUTE_UNIT_8BIT_MACROS_SVH
`define CPU_EXECUTE_UNIT_8BIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CEU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication checked outside reset
`define CEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

@@ sv/ceu_pkg.sv @@
// ----------------------------------------------------------------------------
// ceu_pkg
// types, op codes and constants of the 8-bit execute unit
// ----------------------------------------------------------------------------
package ceu_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);

    localparam logic [7:0] FL_N   = 8'h80;
    localparam logic [7:0] FL_V   = 8'h40;
    localparam logic [7:0] FL_ONE = 8'h20;
    localparam logic [7:0] FL_B   = 8'h10;
    localparam logic [7:0] FL_D   = 8'h08;
    localparam logic [7:0] FL_I   = 8'h04;
    localparam logic [7:0] FL_Z   = 8'h02;
    localparam logic [7:0] FL_C   = 8'h01;

    localparam logic [7:0]  FLAGS_RESET = 8'h24;
    localparam logic [7:0]  SP_RESET    = 8'hFD;

    typedef enum logic [5:0] {
        OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_STA = 6'd3,
        OP_STX = 6'd4,  OP_STY = 6'd5,  OP_CLC = 6'd6,  OP_CLD = 6'd7,
        OP_CLI = 6'd8,  OP_CLV = 6'd9,  OP_SEC = 6'd10, OP_SED = 6'd11,
        OP_SEI = 6'd12, OP_DEC = 6'd13, OP_DEX = 6'd14, OP_DEY = 6'd15,
        OP_INC = 6'd16, OP_INX = 6'd17, OP_INY = 6'd18, OP_AND = 6'd19,
        OP_EOR = 6'd20, OP_ORA = 6'd21, OP_TAX = 6'd22, OP_TAY = 6'd23,
        OP_TSX = 6'd24, OP_TXA = 6'd25, OP_TXS = 6'd26, OP_TYA = 6'd27,
        OP_PHA = 6'd28, OP_PHP = 6'd29, OP_PLA = 6'd30, OP_PLP = 6'd31,
        OP_ADC = 6'd32, OP_ASLM = 6'd33, OP_ASLA = 6'd34, OP_LSRM = 6'd35,
        OP_LSRA = 6'd36, OP_ROLM = 6'd37, OP_ROLA = 6'd38, OP_RORM = 6'd39,
        OP_RORA = 6'd40, OP_SBC = 6'd41, OP_JMP = 6'd42, OP_BCC = 6'd43,
        OP_BCS = 6'd44, OP_BEQ = 6'd45, OP_BMI = 6'd46, OP_BNE = 6'd47,
        OP_BPL = 6'd48, OP_BVC = 6'd49, OP_BVS = 6'd50, OP_CMP = 6'd51,
        OP_CPX = 6'd52, OP_CPY = 6'd53, OP_BIT = 6'd54, OP_JSR = 6'd55,
        OP_BRK = 6'd56, OP_RTS = 6'd57
    } t_op;

    // stack traffic class decided by the front end
    typedef enum logic [1:0] {
        STK_NONE = 2'd0,
        STK_PUSH = 2'd1,
        STK_PULL = 2'd2
    } t_stk;

    // queued word between front and back
    typedef struct packed {
        logic [5:0]  cmd;
        logic [7:0]  operand_value;
        logic [15:0] effective_address;
        logic [15:0] fall_through_pc;
        t_stk        stk;
        logic        two_bytes;
    } t_qword;

    // execution phase of the back end
    typedef enum logic [1:0] {
        PH_EXEC  = 2'd0,
        PH_PULL2 = 2'd1,
        PH_WRITE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  flags;
        logic [7:0]  sp;
        logic [15:0] pc;
        logic        wen;
        logic [15:0] waddr;
        logic [7:0]  wdata;
    } t_result;

endpackage

@@ sv/cpu_execute_unit_8bit.sv @@
// ----------------------------------------------------------------------------
// cpu_execute_unit_8bit
// executes one decoded 8-bit instruction per input word
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | i_valid / o_ready
// out     | output    | o_valid / i_ready
// most words and single pushes finish at the queue head in the back end's exec phase
// pulls and jsr also pass through the write phase, and rts through pull2 and then
// write, set by the registered read port and the single write port of the stack store
// reset is synchronous; the stack store is not cleared
// a stalled output holds the back end; the two-entry queue takes input until it is full
module cpu_execute_unit_8bit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_cmd,
    input  logic [7:0]  i_operand_value,
    input  logic [15:0] i_effective_address,
    input  logic [15:0] i_fall_through_pc,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_x_out,
    output logic [7:0]  o_y_out,
    output logic [7:0]  o_flags_out,
    output logic [7:0]  o_sp_out,
    output logic [15:0] o_pc_out,
    output logic        o_mem_write_en,
    output logic [15:0] o_mem_write_addr,
    output logic [7:0]  o_mem_write_data
);

    logic             q_valid;
    logic             q_pop;
    ceu_pkg::t_qword  q_word;
    ceu_pkg::t_result res;

    // front end and queue
    ceu_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_cmd               (i_cmd),
        .i_operand_value     (i_operand_value),
        .i_effective_address (i_effective_address),
        .i_fall_through_pc   (i_fall_through_pc),
        .o_q_valid           (q_valid),
        .i_q_pop             (q_pop),
        .o_q_word            (q_word)
    );

    // back end
    ceu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_word    (q_word),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready),
        .o_res       (res)
    );

    assign o_acc_out        = res.acc;
    assign o_x_out          = res.x;
    assign o_y_out          = res.y;
    assign o_flags_out      = res.flags;
    assign o_sp_out         = res.sp;
    assign o_pc_out         = res.pc;
    assign o_mem_write_en   = res.wen;
    assign o_mem_write_addr = res.waddr;
    assign o_mem_write_data = res.wdata;

endmodule

@@ sv/ceu_front.sv @@
// ----------------------------------------------------------------------------
// ceu_front
// accepts decoded words, classifies stack traffic and holds a two-entry queue
// ----------------------------------------------------------------------------
module ceu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [5:0]     i_cmd,
    input  logic [7:0]     i_operand_value,
    input  logic [15:0]    i_effective_address,
    input  logic [15:0]    i_fall_through_pc,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output ceu_pkg::t_qword o_q_word
);

    ceu_pkg::t_qword r_q [2];
    logic            r_rd_ptr;
    logic            r_wr_ptr;
    logic [1:0]      r_count;
    ceu_pkg::t_qword n_word;
    logic            push;
    logic            pop;

    // classify the word
    always_comb begin
        n_word.cmd               = i_cmd;
        n_word.operand_value     = i_operand_value;
        n_word.effective_address = i_effective_address;
        n_word.fall_through_pc   = i_fall_through_pc;
        n_word.stk               = ceu_pkg::STK_NONE;
        n_word.two_bytes         = 1'b0;
        unique case (i_cmd)
            ceu_pkg::OP_PHA, ceu_pkg::OP_PHP: n_word.stk = ceu_pkg::STK_PUSH;
            ceu_pkg::OP_JSR: begin
                n_word.stk       = ceu_pkg::STK_PUSH;
                n_word.two_bytes = 1'b1;
            end
            ceu_pkg::OP_PLA, ceu_pkg::OP_PLP: n_word.stk = ceu_pkg::STK_PULL;
            ceu_pkg::OP_RTS: begin
                n_word.stk       = ceu_pkg::STK_PULL;
                n_word.two_bytes = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_ready   = (r_count != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_word  = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_word;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ sv/ceu_back.sv @@
// ----------------------------------------------------------------------------
// ceu_back
// architectural registers, stack store and execution of queued words
// ----------------------------------------------------------------------------
module ceu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  ceu_pkg::t_qword i_q_word,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output ceu_pkg::t_result o_res
);

    logic [7:0]  r_acc, r_x, r_y, r_flags, r_sp;
    logic [7:0]  n_acc, n_x, n_y, n_flags, n_sp;
    logic [7:0]  r_stack [ceu_pkg::STACK_DEPTH];
    logic [7:0]  r_rdata;
    logic [7:0]  r_lo;
    ceu_pkg::t_phase r_phase, n_phase;
    logic        r_out_valid;
    ceu_pkg::t_result r_out, n_out;

    logic        out_free;
    logic        st_we;
    logic [7:0]  st_wdata;
    logic [7:0]  st_waddr;
    logic [7:0]  st_raddr;
    logic        st_re;
    logic        finish;
    logic        hold_pull;

    ceu_pkg::t_qword w;
    logic [7:0]  m;
    logic [15:0] ret;
    logic [8:0]  sum;
    logic [7:0]  addend, res8, sh_in;
    logic        taken;
    logic [7:0]  cmp_reg;
    logic [8:0]  diff;

    assign w        = i_q_word;
    assign m        = w.operand_value;
    assign out_free = !r_out_valid || i_res_ready;
    assign ret      = w.fall_through_pc - 16'd1;

    // phase sequencing: pulls read the store through a registered port before use
    always_comb begin
        n_phase   = r_phase;
        finish    = 1'b0;
        hold_pull = 1'b0;
        st_we     = 1'b0;
        st_wdata  = 8'd0;
        st_waddr  = r_sp;
        st_re     = 1'b0;
        st_raddr  = r_sp + 8'd1;
        unique case (r_phase)
            ceu_pkg::PH_EXEC: begin
                if (i_q_valid) begin
                    if (w.stk == ceu_pkg::STK_PULL) begin
                        st_re   = 1'b1;
                        n_phase = w.two_bytes ? ceu_pkg::PH_PULL2 : ceu_pkg::PH_WRITE;
                    end else if (w.stk == ceu_pkg::STK_PUSH && w.two_bytes) begin
                        st_we    = 1'b1;
                        st_wdata = ret[15:8];
                        n_phase  = ceu_pkg::PH_WRITE;
                    end else if (out_free) begin
                        finish = 1'b1;
                    end
                end
            end
            ceu_pkg::PH_PULL2: begin
                st_re    = 1'b1;
                st_raddr = r_sp + 8'd2;
                n_phase  = ceu_pkg::PH_WRITE;
            end
            ceu_pkg::PH_WRITE: begin
                hold_pull = 1'b1;
                if (out_free) begin
                    finish  = 1'b1;
                    n_phase = ceu_pkg::PH_EXEC;
                end
            end
            default: n_phase = ceu_pkg::PH_EXEC;
        endcase
        if (finish && w.stk == ceu_pkg::STK_PUSH) begin
            st_we    = 1'b1;
            st_waddr = w.two_bytes ? r_sp - 8'd1 : r_sp;
            unique case (w.cmd)
                ceu_pkg::OP_PHA: st_wdata = r_acc;
                ceu_pkg::OP_PHP: st_wdata = r_flags | ceu_pkg::FL_ONE | ceu_pkg::FL_B;
                default:         st_wdata = ret[7:0];
            endcase
        end
    end

    assign o_q_pop = finish;

    // execution of one word
    always_comb begin
        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        n_flags = r_flags;
        n_sp    = r_sp;
        n_out   = '0;
        n_out.pc = w.fall_through_pc;
        addend  = (w.cmd == ceu_pkg::OP_SBC) ? ~m : m;
        sum     = {1'b0, r_acc} + {1'b0, addend} + {8'd0, r_flags[0]};
        res8    = 8'd0;
        sh_in   = (w.cmd[0]) ? m : r_acc;
        taken   = 1'b0;
        unique case (w.cmd)
            ceu_pkg::OP_CPX: cmp_reg = r_x;
            ceu_pkg::OP_CPY: cmp_reg = r_y;
            default:         cmp_reg = r_acc;
        endcase
        diff = {1'b0, cmp_reg} - {1'b0, m};
        unique case (w.cmd)
            ceu_pkg::OP_LDA: n_acc = m;
            ceu_pkg::OP_LDX: n_x = m;
            ceu_pkg::OP_LDY: n_y = m;
            ceu_pkg::OP_STA, ceu_pkg::OP_STX, ceu_pkg::OP_STY: begin
                n_out.wen   = 1'b1;
                n_out.waddr = w.effective_address;
                n_out.wdata = (w.cmd == ceu_pkg::OP_STA) ? r_acc :
                              (w.cmd == ceu_pkg::OP_STX) ? r_x : r_y;
            end
            ceu_pkg::OP_CLC: n_flags = r_flags & ~ceu_pkg::FL_C;
            ceu_pkg::OP_CLD: n_flags = r_flags & ~ceu_pkg::FL_D;
            ceu_pkg::OP_CLI: n_flags = r_flags & ~ceu_pkg::FL_I;
            ceu_pkg::OP_CLV: n_flags = r_flags & ~ceu_pkg::FL_V;
            ceu_pkg::OP_SEC: n_flags = r_flags | ceu_pkg::FL_C;
            ceu_pkg::OP_SED: n_flags = r_flags | ceu_pkg::FL_D;
            ceu_pkg::OP_SEI: n_flags = r_flags | ceu_pkg::FL_I;
            ceu_pkg::OP_BRK: n_flags = r_flags | ceu_pkg::FL_B;
            ceu_pkg::OP_DEC, ceu_pkg::OP_INC: begin
                res8        = (w.cmd == ceu_pkg::OP_INC) ? m + 8'd1 : m - 8'd1;
                n_out.wen   = 1'b1;
                n_out.waddr = w.effective_address;
                n_out.wdata = res8;
            end
            ceu_pkg::OP_DEX: n_x = r_x - 8'd1;
            ceu_pkg::OP_DEY: n_y = r_y - 8'd1;
            ceu_pkg::OP_INX: n_x = r_x + 8'd1;
            ceu_pkg::OP_INY: n_y = r_y + 8'd1;
            ceu_pkg::OP_AND: n_acc = r_acc & m;
            ceu_pkg::OP_EOR: n_acc = r_acc ^ m;
            ceu_pkg::OP_ORA: n_acc = r_acc | m;
            ceu_pkg::OP_TAX: n_x = r_acc;
            ceu_pkg::OP_TAY: n_y = r_acc;
            ceu_pkg::OP_TSX: n_x = r_sp;
            ceu_pkg::OP_TXA: n_acc = r_x;
            ceu_pkg::OP_TXS: n_sp = r_x;
            ceu_pkg::OP_TYA: n_acc = r_y;
            ceu_pkg::OP_PHA, ceu_pkg::OP_PHP: n_sp = r_sp - 8'd1;
            ceu_pkg::OP_PLA: begin
                n_sp  = r_sp + 8'd1;
                n_acc = r_rdata;
            end
            ceu_pkg::OP_PLP: begin
                n_sp    = r_sp + 8'd1;
                n_flags = (r_rdata & ~(ceu_pkg::FL_ONE | ceu_pkg::FL_B)) | ceu_pkg::FL_ONE
                          | (r_flags & ceu_pkg::FL_B);
            end
            ceu_pkg::OP_ADC, ceu_pkg::OP_SBC: begin
                n_acc      = sum[7:0];
                n_flags[0] = sum[8];
                n_flags[6] = ~(r_acc[7] ^ addend[7]) & (r_acc[7] ^ sum[7]);
            end
            ceu_pkg::OP_ASLM, ceu_pkg::OP_ASLA, ceu_pkg::OP_ROLM, ceu_pkg::OP_ROLA,
            ceu_pkg::OP_LSRM, ceu_pkg::OP_LSRA, ceu_pkg::OP_RORM, ceu_pkg::OP_RORA: begin
                unique case (w.cmd)
                    ceu_pkg::OP_ASLM, ceu_pkg::OP_ASLA: begin
                        res8 = {sh_in[6:0], 1'b0};
                        n_flags[0] = sh_in[7];
                    end
                    ceu_pkg::OP_ROLM, ceu_pkg::OP_ROLA: begin
                        res8 = {sh_in[6:0], r_flags[0]};
                        n_flags[0] = sh_in[7];
                    end
                    ceu_pkg::OP_LSRM, ceu_pkg::OP_LSRA: begin
                        res8 = {1'b0, sh_in[7:1]};
                        n_flags[0] = sh_in[0];
                    end
                    default: begin
                        res8 = {r_flags[0], sh_in[7:1]};
                        n_flags[0] = sh_in[0];
                    end
                endcase
                if (w.cmd[0]) begin
                    n_out.wen   = 1'b1;
                    n_out.waddr = w.effective_address;
                    n_out.wdata = res8;
                end else begin
                    n_acc = res8;
                end
            end
            ceu_pkg::OP_JMP: n_out.pc = w.effective_address;
            ceu_pkg::OP_BCC, ceu_pkg::OP_BCS, ceu_pkg::OP_BEQ, ceu_pkg::OP_BMI,
            ceu_pkg::OP_BNE, ceu_pkg::OP_BPL, ceu_pkg::OP_BVC, ceu_pkg::OP_BVS: begin
                unique case (w.cmd)
                    ceu_pkg::OP_BCC: taken = !r_flags[0];
                    ceu_pkg::OP_BCS: taken = r_flags[0];
                    ceu_pkg::OP_BEQ: taken = r_flags[1];
                    ceu_pkg::OP_BMI: taken = r_flags[7];
                    ceu_pkg::OP_BNE: taken = !r_flags[1];
                    ceu_pkg::OP_BPL: taken = !r_flags[7];
                    ceu_pkg::OP_BVC: taken = !r_flags[6];
                    default:         taken = r_flags[6];
                endcase
                if (taken) n_out.pc = w.fall_through_pc + {{8{m[7]}}, m};
            end
            ceu_pkg::OP_CMP, ceu_pkg::OP_CPX, ceu_pkg::OP_CPY: begin
                n_flags[0] = !diff[8];
            end
            ceu_pkg::OP_BIT: begin
                n_flags[1] = ((r_acc & m) == 8'd0);
                n_flags[7] = m[7];
                n_flags[6] = m[6];
            end
            ceu_pkg::OP_JSR: begin
                n_sp     = r_sp - 8'd2;
                n_out.pc = w.effective_address;
            end
            ceu_pkg::OP_RTS: begin
                n_sp     = r_sp + 8'd2;
                n_out.pc = {r_rdata, r_lo} + 16'd1;
            end
            default: ;
        endcase
        // common n and z update
        unique case (w.cmd)
            ceu_pkg::OP_LDA, ceu_pkg::OP_AND, ceu_pkg::OP_EOR, ceu_pkg::OP_ORA,
            ceu_pkg::OP_TXA, ceu_pkg::OP_TYA, ceu_pkg::OP_PLA, ceu_pkg::OP_ADC,
            ceu_pkg::OP_SBC: begin
                n_flags[7] = n_acc[7];
                n_flags[1] = (n_acc == 8'd0);
            end
            ceu_pkg::OP_LDX, ceu_pkg::OP_DEX, ceu_pkg::OP_INX, ceu_pkg::OP_TAX,
            ceu_pkg::OP_TSX: begin
                n_flags[7] = n_x[7];
                n_flags[1] = (n_x == 8'd0);
            end
            ceu_pkg::OP_LDY, ceu_pkg::OP_DEY, ceu_pkg::OP_INY, ceu_pkg::OP_TAY: begin
                n_flags[7] = n_y[7];
                n_flags[1] = (n_y == 8'd0);
            end
            ceu_pkg::OP_DEC, ceu_pkg::OP_INC, ceu_pkg::OP_ASLM, ceu_pkg::OP_ASLA,
            ceu_pkg::OP_ROLM, ceu_pkg::OP_ROLA, ceu_pkg::OP_LSRM, ceu_pkg::OP_LSRA,
            ceu_pkg::OP_RORM, ceu_pkg::OP_RORA: begin
                n_flags[7] = res8[7];
                n_flags[1] = (res8 == 8'd0);
            end
            ceu_pkg::OP_CMP, ceu_pkg::OP_CPX, ceu_pkg::OP_CPY: begin
                n_flags[7] = diff[7];
                n_flags[1] = (diff[7:0] == 8'd0);
            end
            default: ;
        endcase
        n_out.acc   = n_acc;
        n_out.x     = n_x;
        n_out.y     = n_y;
        n_out.flags = n_flags;
        n_out.sp    = n_sp;
    end

    // stack store, registered read
    always_ff @(posedge i_clk) begin
        if (st_we) r_stack[st_waddr[ceu_pkg::STACK_AW-1:0]] <= st_wdata;
        if (st_re) begin
            r_rdata <= r_stack[st_raddr[ceu_pkg::STACK_AW-1:0]];
            if (r_phase == ceu_pkg::PH_PULL2) r_lo <= r_rdata;
        end else if (!hold_pull) begin
            r_rdata <= r_rdata;
        end
    end

    // architectural registers and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 8'd0;
            r_x         <= 8'd0;
            r_y         <= 8'd0;
            r_flags     <= ceu_pkg::FLAGS_RESET;
            r_sp        <= ceu_pkg::SP_RESET;
            r_phase     <= ceu_pkg::PH_EXEC;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (finish) begin
                r_acc       <= n_acc;
                r_x         <= n_x;
                r_y         <= n_y;
                r_flags     <= n_flags;
                r_sp        <= n_sp;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) r_out <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

@@ sv/ceu_checker.sv @@
// ----------------------------------------------------------------------------
// ceu_checker
// port-level checks of the execute unit
// ----------------------------------------------------------------------------
`include "cpu_execute_unit_8bit_macros.svh"

module ceu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_flags_out,
    input logic        o_mem_write_en,
    input logic [15:0] o_mem_write_addr,
    input logic [7:0]  o_mem_write_data
);

    // bit five of the status byte is always set
    `CEU_ASSERT_IMPL(a_flag_one, i_clk, i_rst_n, o_valid, o_flags_out[5])
    // no write means zero address and data
    `CEU_ASSERT_IMPL(a_no_write, i_clk, i_rst_n, o_valid && !o_mem_write_en,
        o_mem_write_addr == 16'd0 && o_mem_write_data == 8'd0)
    // stalled word holds
    `CEU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_flags_out))

endmodule

bind cpu_execute_unit_8bit ceu_checker u_ceu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_flags_out      (o_flags_out),
    .o_mem_write_en   (o_mem_write_en),
    .o_mem_write_addr (o_mem_write_addr),
    .o_mem_write_data (o_mem_write_data)
);
